// ===== sv/breakpoint_envelope_shaper_macros.svh =====
// assertion macros shared by the envelope shaper rtl
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef BREAKPOINT_ENVELOPE_SHAPER_MACROS_SVH
`define BREAKPOINT_ENVELOPE_SHAPER_MACROS_SVH

// property that must hold in the same cycle as its condition
`define BES_ASSERT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// property that must hold in the cycle after its condition
`define BES_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== sv/bes_pkg.sv =====
// types and constants of the breakpoint envelope shaper
// no dependencies
`timescale 1ns / 1ps

package bes_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned LVL_W     = 17;
  localparam int unsigned PT_W      = 50;
  localparam int unsigned NKNOT     = 5;

  localparam logic [LVL_W-1:0] ONE = 17'h10000;

  localparam logic [PT_W-1:0] PT1_RST = 50'd2147549184;
  localparam logic [PT_W-1:0] PT2_RST = 50'd4295000064;
  localparam logic [PT_W-1:0] PT3_RST = 50'd6442483712;
  localparam logic [PT_W-1:0] PT4_RST = 50'd8589934592;

  typedef enum logic [2:0] {
    CFG_START_LEVEL = 3'd0,
    CFG_POINT_ONE   = 3'd1,
    CFG_POINT_TWO   = 3'd2,
    CFG_POINT_THREE = 3'd3,
    CFG_POINT_FOUR  = 3'd4,
    CFG_DEPTH_GAIN  = 3'd5,
    CFG_BIPOLAR     = 3'd6,
    CFG_ACTIVE      = 3'd7
  } cfg_idx_e;

  // everything one item carries down the pipeline
  typedef struct packed {
    logic               found;
    logic               ret;
    logic               lin;
    logic               up;
    logic [16:0]        x;
    logic [16:0]        x1;
    logic [16:0]        y1;
    logic [16:0]        x2;
    logic [16:0]        y2;
    logic signed [15:0] crv;
    logic [16:0]        dx;
    logic [16:0]        run;
    logic [16:0]        rx;
    logic [16:0]        rise;
    logic [17:0]        fac_x;
    logic [17:0]        fac_y;
    logic [34:0]        pxb;
    logic [34:0]        pyb;
    logic [33:0]        pl1;
    logic [33:0]        pl2;
    logic [16:0]        bq;
    logic [16:0]        yb;
    logic signed [18:0] aq;
    logic [32:0]        num;
    logic [33:0]        bb;
    logic signed [36:0] adx;
    logic [33:0]        disc;
    logic [19:0]        sq_rem;
    logic [16:0]        sq_root;
    logic [32:0]        dv_n;
    logic [17:0]        dv_d;
    logic [18:0]        dv_rem;
    logic [16:0]        dv_q;
    logic               dv_ovf;
    logic [16:0]        t;
    logic [16:0]        u;
    logic [33:0]        uu;
    logic [33:0]        tu;
    logic [33:0]        tt;
    logic [16:0]        w0;
    logic [16:0]        w1;
    logic [16:0]        w2;
    logic [33:0]        p0;
    logic [33:0]        p1;
    logic [33:0]        p2;
    logic [16:0]        lvl;
    logic [33:0]        dprod;
    logic signed [17:0] drive;
  } pipe_t;

  function automatic logic [LVL_W-1:0] sat_one(input logic [LVL_W-1:0] v);
    return (v > ONE) ? ONE : v;
  endfunction

endpackage

// ===== sv/breakpoint_envelope_shaper.sv =====
// breakpoint envelope shaper: phase in, shape level and scaled drive out
// 32 register stages, S_SEL to S_OUT; a result is offered from the S_OUT register
// one item per cycle sustained while the output is not stalled, bubbles close up under output stalls
// square root runs 2 bits a stage (1 in its last), divider 2 steps a stage
// reset clears all stage valids and loads the default shape into the config registers
// depends on bes_pkg and breakpoint_envelope_shaper_macros.svh
`timescale 1ns / 1ps
`include "breakpoint_envelope_shaper_macros.svh"

module breakpoint_envelope_shaper (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [49:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // phase[15:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // shape_level[16:0], drive_value[34:17], zero pad
);
  import bes_pkg::*;

  localparam int NSTG    = 32;
  localparam int S_SEL   = 0;
  localparam int S_PRE   = 1;
  localparam int S_MUL1  = 2;
  localparam int S_CTL   = 3;
  localparam int S_MUL2  = 4;
  localparam int S_DISC  = 5;
  localparam int S_SQ    = 6;
  localparam int N_SQ    = 9;
  localparam int S_DEN   = 15;
  localparam int S_DV    = 16;
  localparam int N_DV    = 9;
  localparam int S_TSAT  = 25;
  localparam int S_MUL3  = 26;
  localparam int S_WGT   = 27;
  localparam int S_MUL4  = 28;
  localparam int S_LVL   = 29;
  localparam int S_MUL5  = 30;
  localparam int S_OUT   = 31;

  // configuration registers
  logic [16:0] start_level_q;
  logic [49:0] pt_q [4];
  logic [16:0] depth_q;
  logic        bipolar_q;
  logic [2:0]  active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_level_q <= '0;
      pt_q[0]       <= PT1_RST;
      pt_q[1]       <= PT2_RST;
      pt_q[2]       <= PT3_RST;
      pt_q[3]       <= PT4_RST;
      depth_q       <= ONE;
      bipolar_q     <= 1'b0;
      active_q      <= 3'd4;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_START_LEVEL: start_level_q <= cfg_data_i[16:0];
        CFG_POINT_ONE:   pt_q[0]       <= cfg_data_i;
        CFG_POINT_TWO:   pt_q[1]       <= cfg_data_i;
        CFG_POINT_THREE: pt_q[2]       <= cfg_data_i;
        CFG_POINT_FOUR:  pt_q[3]       <= cfg_data_i;
        CFG_DEPTH_GAIN:  depth_q       <= cfg_data_i[16:0];
        CFG_BIPOLAR:     bipolar_q     <= cfg_data_i[0];
        CFG_ACTIVE:      active_q      <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // decoded knots, index 0 is the start level at time zero
  logic [16:0]        kl [NKNOT];
  logic [16:0]        kt [NKNOT];
  logic signed [15:0] kc [NKNOT];
  logic [2:0]         n_act;

  always_comb begin
    kl[0] = sat_one(start_level_q);
    kt[0] = '0;
    kc[0] = '0;
    for (int i = 1; i < NKNOT; i++) begin
      kl[i] = sat_one(pt_q[i-1][16:0]);
      kt[i] = sat_one(pt_q[i-1][33:17]);
      kc[i] = pt_q[i-1][49:34];
    end
    if (active_q == 3'd0) begin
      n_act = 3'd1;
    end else if (active_q > 3'd4) begin
      n_act = 3'd4;
    end else begin
      n_act = active_q;
    end
  end

  // pipeline stages with a ready chain so bubbles close up
  pipe_t             st_q [NSTG];
  pipe_t             st_d [NSTG];
  logic [NSTG-1:0]   vld_q;
  logic [NSTG-1:0]   en;

  always_comb begin
    en[NSTG-1] = !vld_q[NSTG-1] || m_axis_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NSTG; k++) begin
      if (en[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  // segment search
  always_comb begin
    logic [2:0]  sel;
    logic        fnd;
    logic [16:0] x;
    x   = {1'b0, s_axis_tdata};
    sel = 3'd1;
    fnd = 1'b0;
    for (int i = NKNOT - 1; i >= 1; i--) begin
      if (3'(i) <= n_act && kt[i] > x) begin
        sel = 3'(i);
        fnd = 1'b1;
      end
    end
    st_d[S_SEL]       = '0;
    st_d[S_SEL].x     = x;
    st_d[S_SEL].found = fnd;
    if (fnd) begin
      st_d[S_SEL].x1  = kt[sel - 3'd1];
      st_d[S_SEL].y1  = kl[sel - 3'd1];
      st_d[S_SEL].x2  = kt[sel];
      st_d[S_SEL].y2  = kl[sel];
      st_d[S_SEL].crv = kc[sel];
    end else begin
      // past the last knot its level holds
      st_d[S_SEL].x1  = kt[n_act];
      st_d[S_SEL].y1  = kl[n_act];
      st_d[S_SEL].x2  = ONE;
      st_d[S_SEL].y2  = kl[n_act];
      st_d[S_SEL].crv = kc[n_act];
    end
    st_d[S_SEL].lin = (st_d[S_SEL].crv == '0);
  end

  // clamp, segment geometry, control point factors
  always_comb begin
    pipe_t              p;
    logic [16:0]        xc;
    logic signed [17:0] cs;
    logic signed [18:0] fp;
    logic signed [18:0] fm;
    p  = st_q[S_PRE-1];
    xc = p.x;
    if (xc < p.x1) xc = p.x1;
    if (xc > p.x2) xc = p.x2;
    cs = {p.crv[15], p.crv, 1'b0};
    fp = 19'sd65536 + 19'(cs);
    fm = 19'sd65536 - 19'(cs);
    st_d[S_PRE]       = p;
    st_d[S_PRE].ret   = !p.found || (p.x2 <= p.x1) || (!p.lin && p.y1 == p.y2);
    st_d[S_PRE].dx    = xc - p.x1;
    st_d[S_PRE].rx    = p.x2 - xc;
    st_d[S_PRE].run   = p.x2 - p.x1;
    st_d[S_PRE].up    = p.y2 > p.y1;
    st_d[S_PRE].rise  = (p.y2 > p.y1) ? (p.y2 - p.y1) : (p.y1 - p.y2);
    st_d[S_PRE].fac_x = fp[17:0];
    st_d[S_PRE].fac_y = (p.y2 > p.y1) ? fm[17:0] : fp[17:0];
  end

  always_comb begin
    pipe_t p;
    p = st_q[S_MUL1-1];
    st_d[S_MUL1]     = p;
    st_d[S_MUL1].pxb = 35'(p.run) * 35'(p.fac_x);
    st_d[S_MUL1].pyb = 35'(p.rise) * 35'(p.fac_y);
    st_d[S_MUL1].pl1 = 34'(p.y1) * 34'(p.rx);
    st_d[S_MUL1].pl2 = 34'(p.y2) * 34'(p.dx);
  end

  always_comb begin
    pipe_t       p;
    logic [34:0] bsum;
    logic [34:0] ysum;
    logic [16:0] b;
    p    = st_q[S_CTL-1];
    bsum = (p.pxb + 35'h10000) >> 17;
    ysum = (p.pyb + 35'h10000) >> 17;
    b    = bsum[16:0];
    st_d[S_CTL]     = p;
    st_d[S_CTL].bq  = b;
    st_d[S_CTL].aq  = $signed({2'b00, p.run}) - $signed({1'b0, b, 1'b0});
    st_d[S_CTL].yb  = (p.up ? p.y1 : p.y2) + ysum[16:0];
    st_d[S_CTL].num = 33'(p.pl1 + p.pl2);
  end

  always_comb begin
    pipe_t p;
    p = st_q[S_MUL2-1];
    st_d[S_MUL2]     = p;
    st_d[S_MUL2].bb  = 34'(p.bq) * 34'(p.bq);
    st_d[S_MUL2].adx = 37'(p.aq) * 37'($signed({1'b0, p.dx}));
  end

  always_comb begin
    pipe_t              p;
    logic signed [37:0] ds;
    p  = st_q[S_DISC-1];
    ds = 38'($signed({1'b0, p.bb})) + 38'(p.adx);
    st_d[S_DISC]         = p;
    st_d[S_DISC].disc    = (ds < 0) ? '0 : ds[33:0];
    st_d[S_DISC].sq_rem  = '0;
    st_d[S_DISC].sq_root = '0;
  end

  // integer square root, two result bits per stage, one in the last
  for (genvar g = 0; g < N_SQ; g++) begin : g_sq
    always_comb begin
      pipe_t       p;
      logic [19:0] rem;
      logic [19:0] trial;
      logic [16:0] root;
      int          it;
      int          idx;
      p    = st_q[S_SQ+g-1];
      rem  = p.sq_rem;
      root = p.sq_root;
      for (int s = 0; s < 2; s++) begin
        it = 2 * g + s;
        if (it < 17) begin
          idx   = 33 - 2 * it;
          rem   = {rem[17:0], p.disc[idx], p.disc[idx-1]};
          trial = {1'b0, root, 2'b01};
          if (rem >= trial) begin
            rem  = rem - trial;
            root = {root[15:0], 1'b1};
          end else begin
            root = {root[15:0], 1'b0};
          end
        end
      end
      st_d[S_SQ+g]         = p;
      st_d[S_SQ+g].sq_rem  = rem;
      st_d[S_SQ+g].sq_root = root;
    end
  end

  // divider operands: linear blend or bezier parameter
  always_comb begin
    pipe_t       p;
    logic [17:0] den;
    p   = st_q[S_DEN-1];
    den = 18'(p.bq) + 18'(p.sq_root);
    st_d[S_DEN] = p;
    if (p.lin) begin
      st_d[S_DEN].dv_n = p.num + 33'(p.run >> 1);
      st_d[S_DEN].dv_d = {1'b0, p.run};
    end else begin
      st_d[S_DEN].dv_n = {p.dx, 16'h0000} + 33'(den >> 1);
      st_d[S_DEN].dv_d = den;
    end
    st_d[S_DEN].ret    = p.ret || (!p.lin && den == '0);
    st_d[S_DEN].dv_rem = '0;
    st_d[S_DEN].dv_q   = '0;
    st_d[S_DEN].dv_ovf = 1'b0;
  end

  // restoring divider: first step checks overflow, then one quotient bit per step
  for (genvar g = 0; g < N_DV; g++) begin : g_dv
    always_comb begin
      pipe_t       p;
      logic [18:0] rem;
      logic [16:0] q;
      logic        ovf;
      int          st;
      int          j;
      p   = st_q[S_DV+g-1];
      rem = p.dv_rem;
      q   = p.dv_q;
      ovf = p.dv_ovf;
      for (int s = 0; s < 2; s++) begin
        st = 2 * g + s;
        if (st == 0) begin
          rem = 19'(p.dv_n[32:17]);
          ovf = rem >= {1'b0, p.dv_d};
        end else if (st < 18) begin
          j   = 17 - st;
          rem = {rem[17:0], p.dv_n[j]};
          if (rem >= {1'b0, p.dv_d}) begin
            rem  = rem - {1'b0, p.dv_d};
            q[j] = 1'b1;
          end
        end
      end
      st_d[S_DV+g]        = p;
      st_d[S_DV+g].dv_rem = rem;
      st_d[S_DV+g].dv_q   = q;
      st_d[S_DV+g].dv_ovf = ovf;
    end
  end

  always_comb begin
    pipe_t       p;
    logic [16:0] t;
    p = st_q[S_TSAT-1];
    t = p.dv_ovf ? ONE : sat_one(p.dv_q);
    st_d[S_TSAT]   = p;
    st_d[S_TSAT].t = t;
    st_d[S_TSAT].u = ONE - t;
  end

  always_comb begin
    pipe_t p;
    p = st_q[S_MUL3-1];
    st_d[S_MUL3]    = p;
    st_d[S_MUL3].uu = 34'(p.u) * 34'(p.u);
    st_d[S_MUL3].tu = 34'(p.t) * 34'(p.u);
    st_d[S_MUL3].tt = 34'(p.t) * 34'(p.t);
  end

  always_comb begin
    pipe_t       p;
    logic [34:0] a0;
    logic [34:0] a1;
    logic [34:0] a2;
    p  = st_q[S_WGT-1];
    a0 = (35'(p.uu) + 35'h8000) >> 16;
    a1 = ({p.tu, 1'b0} + 35'h8000) >> 16;
    a2 = (35'(p.tt) + 35'h8000) >> 16;
    st_d[S_WGT]    = p;
    st_d[S_WGT].w0 = a0[16:0];
    st_d[S_WGT].w1 = a1[16:0];
    st_d[S_WGT].w2 = a2[16:0];
  end

  always_comb begin
    pipe_t p;
    p = st_q[S_MUL4-1];
    st_d[S_MUL4]    = p;
    st_d[S_MUL4].p0 = 34'(p.w0) * 34'(p.y1);
    st_d[S_MUL4].p1 = 34'(p.w1) * 34'(p.yb);
    st_d[S_MUL4].p2 = 34'(p.w2) * 34'(p.y2);
  end

  always_comb begin
    pipe_t       p;
    logic [35:0] sum;
    logic [35:0] bz;
    logic [16:0] bzs;
    p   = st_q[S_LVL-1];
    sum = 36'(p.p0) + 36'(p.p1) + 36'(p.p2) + 36'h8000;
    bz  = sum >> 16;
    bzs = (bz > 36'(ONE)) ? ONE : bz[16:0];
    st_d[S_LVL] = p;
    if (p.ret) begin
      st_d[S_LVL].lvl = p.y1;
    end else if (p.lin) begin
      st_d[S_LVL].lvl = p.t;
    end else begin
      st_d[S_LVL].lvl = bzs;
    end
  end

  always_comb begin
    pipe_t p;
    p = st_q[S_MUL5-1];
    st_d[S_MUL5]       = p;
    st_d[S_MUL5].dprod = 34'(p.lvl) * 34'(sat_one(depth_q));
  end

  always_comb begin
    pipe_t       p;
    logic [33:0] dr;
    p  = st_q[S_OUT-1];
    dr = (p.dprod + 34'h8000) >> 16;
    st_d[S_OUT] = p;
    if (bipolar_q) begin
      st_d[S_OUT].drive = $signed({dr[16:0], 1'b0} - 18'h10000);
    end else begin
      st_d[S_OUT].drive = $signed({1'b0, dr[16:0]});
    end
  end

  assign m_axis_tvalid = vld_q[S_OUT];
  assign m_axis_tdata  = {5'b00000, st_q[S_OUT].drive, st_q[S_OUT].lvl};

  logic       in_xfer;
  logic       out_xfer;
  logic [5:0] n_items;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign n_items  = 6'($countones(vld_q));

  `BES_ASSERT(a_full_on_stall, !s_axis_tready, &vld_q, "input stalled with a bubble in the pipe")
  `BES_ASSERT_NEXT(a_fill_count, in_xfer && !out_xfer, n_items == $past(n_items) + 6'd1, "fill")
  `BES_ASSERT(a_level_range, m_axis_tvalid, st_q[S_OUT].lvl <= ONE, "shape level above one")

endmodule

// ===== verif/tb_top.sv =====
// testbench for the breakpoint envelope shaper: directed and random phases, mostly under
// random stalls, each result checked against an in-bench fixed-point predictor
// depends on bes_pkg and breakpoint_envelope_shaper
`timescale 1ns / 1ps

module tb_top;
  import bes_pkg::*;

  localparam int LATENCY = 32;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [16:0] level;
    logic [17:0] drive;
  } shape_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [49:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  breakpoint_envelope_shaper uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // shadow copy of the configuration registers
  logic [16:0] sh_start;
  logic [49:0] sh_pt [1:4];
  logic [16:0] sh_depth;
  logic        sh_bipolar;
  logic [2:0]  sh_active;

  shape_out_t expected_q[$];
  int errors = 0;
  int checked = 0;
  int cycles = 0;
  int sink_gap = 0;
  bit sink_idle_en = 1'b1;
  bit src_idle_en = 1'b1;
  bit hold_sink = 1'b0;

  initial forever #4 clk_i = ~clk_i;

  function automatic longint unsigned sat1(longint unsigned v);
    return (v > 65536) ? 65536 : v;
  endfunction

  function automatic longint unsigned round_div(longint unsigned n, longint unsigned d);
    return (n + d / 2) / d;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // knot k: level, time, curve; knot 0 is the start level at time zero
  function automatic void knot(input int k, output longint unsigned lv,
                               output longint unsigned tm, output longint signed cv);
    if (k == 0) begin
      lv = sat1(sh_start);
      tm = 0;
      cv = 0;
    end else begin
      lv = sat1(sh_pt[k][16:0]);
      tm = sat1(sh_pt[k][33:17]);
      cv = $signed(sh_pt[k][49:34]);
    end
  endfunction

  function automatic longint unsigned curve_level(longint unsigned x, longint unsigned x1,
      longint unsigned y1, longint unsigned x2, longint unsigned y2, longint signed cv);
    longint signed c, bq, aq, disc;
    longint unsigned run, rise, xb, yb, dx, den, t, u, w0, w1, w2;
    if (x2 <= x1 || y1 == y2) return y1;
    if (x < x1) x = x1;
    if (x > x2) x = x2;
    c = cv * 2 * 65536 / 65536;
    if (c > 65536) c = 65536;
    if (c < -65536) c = -65536;
    run = x2 - x1;
    xb = x1 + round_div(run * longint'(65536 + c), 2 * 65536);
    if (y2 > y1) begin
      rise = y2 - y1;
      yb = y1 + round_div(rise * longint'(65536 - c), 2 * 65536);
    end else begin
      rise = y1 - y2;
      yb = y2 + round_div(rise * longint'(65536 + c), 2 * 65536);
    end
    dx = x - x1;
    bq = xb - x1;
    aq = longint'(x1) - 2 * longint'(xb) + longint'(x2);
    disc = bq * bq + aq * longint'(dx);
    if (disc < 0) disc = 0;
    den = bq + floor_sqrt(disc);
    if (den == 0) return y1;
    t = sat1(round_div(dx << 16, den));
    u = 65536 - t;
    w0 = round_div(u * u, 65536);
    w1 = round_div(2 * t * u, 65536);
    w2 = round_div(t * t, 65536);
    return sat1(round_div(w0 * y1 + w1 * yb + w2 * y2, 65536));
  endfunction

  function automatic shape_out_t predict_shape(logic [15:0] phase);
    shape_out_t r;
    longint unsigned x, n, l1, t1, l2, t2, lv, tm, v, dr;
    longint signed c1, c2, cv, d;
    bit hit;
    x = phase;
    n = sh_active;
    if (n < 1) n = 1;
    if (n > 4) n = 4;
    knot(0, l1, t1, c1);
    hit = 0;
    for (int i = 1; i <= n; i++) begin
      knot(i, lv, tm, cv);
      if (!hit && tm > x) begin
        knot(i - 1, l1, t1, c1);
        l2 = lv; t2 = tm; c2 = cv;
        hit = 1;
      end
    end
    if (!hit) begin
      knot(n, l1, t1, c1);
      l2 = l1; t2 = 65536; c2 = c1;
    end
    if (c2 == 0) begin
      if (t2 <= t1) begin
        v = l1;
      end else begin
        if (x < t1) x = t1;
        if (x > t2) x = t2;
        v = sat1(round_div(l1 * (t2 - x) + l2 * (x - t1), t2 - t1));
      end
    end else begin
      v = curve_level(x, t1, l1, t2, l2, c2);
    end
    dr = round_div(v * sat1(sh_depth), 65536);
    d = dr;
    if (sh_bipolar) d = 2 * d - 65536;
    r.level = v[16:0];
    r.drive = d[17:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch on %s at result %0d: got %0h, want %0h", what, checked, got, want);
  endtask

  // config writes happen only while the pipeline is drained
  task automatic write_reg(input cfg_idx_e idx, input logic [49:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_START_LEVEL: sh_start = val[16:0];
      CFG_POINT_ONE:   sh_pt[1] = val;
      CFG_POINT_TWO:   sh_pt[2] = val;
      CFG_POINT_THREE: sh_pt[3] = val;
      CFG_POINT_FOUR:  sh_pt[4] = val;
      CFG_DEPTH_GAIN:  sh_depth = val[16:0];
      CFG_BIPOLAR:     sh_bipolar = val[0];
      CFG_ACTIVE:      sh_active = val[2:0];
      default: ;
    endcase
  endtask

  // valid stays up between back-to-back transfers, drain drops it
  task automatic send_phase(input logic [15:0] phase);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= phase;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_q.push_back(predict_shape(phase));
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  function automatic logic [49:0] make_point(logic [16:0] lv, logic [16:0] tm,
                                             logic [15:0] cv);
    return {cv, tm, lv};
  endfunction

  // random curve mostly within the nominal range, sometimes anywhere
  function automatic logic [15:0] rand_curve();
    case ($urandom_range(0, 3))
      0: return 16'h0;
      1: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 65536)) - 32768);
    endcase
  endfunction

  task automatic random_shape(input bit ordered);
    logic [16:0] tms [1:4];
    for (int i = 1; i <= 4; i++) tms[i] = 17'($urandom_range(0, 65536));
    if (ordered) tms.sort();
    write_reg(CFG_START_LEVEL, $urandom_range(0, 9) == 0 ? 50'($urandom) :
              50'($urandom_range(0, 65536)));
    for (int i = 1; i <= 4; i++)
      write_reg(cfg_idx_e'(i), $urandom_range(0, 9) == 0 ? 50'({$urandom, $urandom}) :
                make_point(17'($urandom_range(0, 65536)), tms[i], rand_curve()));
    write_reg(CFG_DEPTH_GAIN, $urandom_range(0, 9) == 0 ? 50'($urandom) :
              50'($urandom_range(0, 65536)));
    write_reg(CFG_BIPOLAR, 50'($urandom_range(0, 1)));
    write_reg(CFG_ACTIVE, $urandom_range(0, 9) == 0 ? 50'($urandom_range(0, 7)) :
              50'($urandom_range(1, 4)));
  endtask

  task automatic test_reset_shape;
    send_phase(16'h0000);
    send_phase(16'h3FFF);
    send_phase(16'h4000);
    send_phase(16'h8000);
    send_phase(16'hBFFF);
    send_phase(16'hC000);
    send_phase(16'hFFFF);
    drain();
  endtask

  task automatic test_special_cases;
    // curved flat and vertical segments, extreme curves, saturated levels
    write_reg(CFG_START_LEVEL, 50'h1FFFF);
    write_reg(CFG_POINT_ONE, make_point(17'h1FFFF, 17'h4000, 16'h7FFF));
    write_reg(CFG_POINT_TWO, make_point(17'h08000, 17'h4000, 16'h8000));
    write_reg(CFG_POINT_THREE, make_point(17'h08000, 17'h8000, 16'h4000));
    write_reg(CFG_POINT_FOUR, make_point(17'h00000, 17'h1FFFF, 16'hC000));
    write_reg(CFG_DEPTH_GAIN, 50'h1FFFF);
    write_reg(CFG_BIPOLAR, 50'd1);
    write_reg(CFG_ACTIVE, 50'd0);
    send_phase(16'h0000); send_phase(16'h2000); send_phase(16'hFFFF);
    drain();
    write_reg(CFG_ACTIVE, 50'd7);
    send_phase(16'h1000); send_phase(16'h4000); send_phase(16'h6000);
    send_phase(16'h9000); send_phase(16'hFFFF);
    drain();
    // unordered times and a zero depth
    write_reg(CFG_POINT_ONE, make_point(17'h10000, 17'hC000, 16'h0));
    write_reg(CFG_POINT_TWO, make_point(17'h00000, 17'h2000, 16'h1234));
    write_reg(CFG_DEPTH_GAIN, 50'd0);
    write_reg(CFG_ACTIVE, 50'd2);
    send_phase(16'h1000); send_phase(16'hD000); send_phase(16'h5555);
    drain();
    write_reg(CFG_DEPTH_GAIN, 50'h10000);
    write_reg(CFG_BIPOLAR, 50'd0);
    write_reg(CFG_ACTIVE, 50'd4);
  endtask

  task automatic test_random_shapes(input int sets, input int per_set);
    for (int s = 0; s < sets; s++) begin
      random_shape($urandom_range(0, 4) != 0);
      for (int k = 0; k < per_set; k++) send_phase(16'($urandom));
      drain();
    end
  endtask

  // sink holds off while the source keeps offering, filling the pipeline
  task automatic test_backpressure;
    hold_sink = 1'b1;
    fork
      begin
        for (int k = 0; k < 60; k++) send_phase(16'($urandom));
      end
      begin
        repeat (150) @(posedge clk_i);
        hold_sink = 1'b0;
      end
    join
    drain();
  endtask

  // sink idles in random bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_sink) begin
      m_axis_tready <= 1'b0;
    end else if (sink_idle_en && sink_gap > 0) begin
      sink_gap--;
      m_axis_tready <= 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 9) == 0) begin
      sink_gap = $urandom_range(0, 7);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    shape_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transfer", m_axis_tdata, 0);
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tdata[16:0] !== want.level)
          report_mismatch("shape_level", m_axis_tdata[16:0], want.level);
        if (m_axis_tdata[34:17] !== want.drive)
          report_mismatch("drive_value", m_axis_tdata[34:17], want.drive);
      end
      checked++;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    sh_start = '0;
    sh_pt[1] = PT1_RST; sh_pt[2] = PT2_RST; sh_pt[3] = PT3_RST; sh_pt[4] = PT4_RST;
    sh_depth = 17'h10000;
    sh_bipolar = 1'b0;
    sh_active = 3'd4;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_shape();
    test_special_cases();
    test_backpressure();
    test_random_shapes(30, 14);
    sink_idle_en = 1'b0;
    src_idle_en = 1'b0;
    test_random_shapes(6, 15);
    $display("covered reset shape, saturation and curved corner cases, a long sink stall");
    $display("and %0d results over random shapes, modes and point counts", checked);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
